@@ src/kli_pkg.sv @@
// Package for the keyframe linear interpolator: op codes, states, command and status types.
`default_nettype none
package kli_pkg;
	localparam int unsigned MaxRowsDefault = 256;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SEG_RD,
		ST_SEG_K1,
		ST_DIV,
		ST_LERP_RD,
		ST_LERP_MUL,
		ST_LERP_ADD,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic clear;
		logic append;
		logic scan_rd;
		logic seg_rd_k0;
		logic seg_rd_k1;
		logic div_start;
		logic lerp_rd;
		logic lerp_mul;
		logic lerp_add;
		logic copy_rd;
		logic copy_wr;
		logic set_empty;
		logic scan_next;
		logic capture_in;
	} cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic key_ge;
		logic scan_last;
		logic scan_first;
		logic single_row;
		logic div_done;
		logic lerp_last;
	} stat_t;
endpackage
`default_nettype wire

@@ src/kli_ctrl.sv @@
// Controller state machine for the keyframe linear interpolator.
`default_nettype none
module kli_ctrl
	import kli_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire logic [1:0] operation,
	output logic       out_valid,
	input  wire logic  out_stall,
	input  stat_t      stat,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				// input is open here, so a valid beat is taken this cycle
				if (in_valid) begin
					cmd.capture_in = 1'b1;
					case (op_t'(operation))
						OP_CLEAR:  cmd.clear = 1'b1;
						OP_APPEND: cmd.append = !stat.full;
						OP_QUERY: begin
							if (stat.empty) begin
								cmd.set_empty = 1'b1;
								state_d = ST_OUT;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (stat.key_ge) begin
					if (stat.scan_first && stat.single_row) state_d = ST_COPY_RD;
					else state_d = ST_SEG_RD;
				end else if (stat.scan_last) begin
					state_d = ST_COPY_RD;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SEG_RD: begin
				cmd.seg_rd_k0 = 1'b1;
				state_d = ST_SEG_K1;
			end
			ST_SEG_K1: begin
				cmd.seg_rd_k1 = 1'b1;
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_LERP_RD;
			end
			ST_LERP_RD: begin
				cmd.lerp_rd = 1'b1;
				state_d = ST_LERP_MUL;
			end
			ST_LERP_MUL: begin
				cmd.lerp_mul = 1'b1;
				state_d = ST_LERP_ADD;
			end
			ST_LERP_ADD: begin
				cmd.lerp_add = 1'b1;
				state_d = stat.lerp_last ? ST_OUT : ST_LERP_RD;
			end
			ST_COPY_RD: begin
				cmd.copy_rd = 1'b1;
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ src/kli_div.sv @@
// Restoring divider for alpha = (el << 16) / den, one quotient bit per cycle.
`default_nettype none
module kli_div
	import kli_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] el,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [15:0]      alpha
);
	localparam int unsigned QBits = 48;

	logic [47:0] num_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], num_q[47]};
	assign trial   = shifted - {1'b0, den_q};

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(QBits);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	// Shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {el, 16'h0};
			rem_q <= '0;
			quo_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign done  = !busy_q && !start;
	assign alpha = (den_q == '0) ? 16'h0 :
		((quo_q[47:16] != '0) ? 16'hFFFF : quo_q[15:0]);
endmodule
`default_nettype wire

@@ src/kli_dp.sv @@
// Datapath: row memories, key scan, divider and a shared lerp unit.
`default_nettype none
module kli_dp
	import kli_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MaxRowsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  wire logic [31:0] time_value,
	input  wire logic [31:0] ctrl_x_in,
	input  wire logic [31:0] ctrl_y_in,
	input  wire logic [31:0] ctrl_z_in,
	input  wire logic [31:0] ball_x_in,
	input  wire logic [31:0] ball_y_in,
	input  wire logic [31:0] ball_z_in,
	input  wire logic [15:0] ball_index_in,
	input  wire logic [31:0] round_score_in,
	input  wire logic [31:0] total_score_in,
	input  wire logic [31:0] distance_in,
	output logic [31:0]      res_q [9],
	output logic [31:0]      elapsed_q,
	output logic [15:0]      ball_index_q,
	output logic             empty_q
);
	localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW = $clog2(MAX_ROWS + 1);

	// One wide row of nine values per memory entry
	logic [31:0] key_mem   [MAX_ROWS];
	logic [31:0] delta_mem [MAX_ROWS];
	logic [15:0] bnum_mem  [MAX_ROWS];
	logic [9*32-1:0] val_mem [MAX_ROWS];

	logic [CW-1:0] row_count_q;
	logic [31:0]   run_time_q;
	logic [31:0]   t_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] rd_addr;
	logic [31:0]   key_rd_q;
	logic [31:0]   delta_rd_q;
	logic [15:0]   bnum_rd_q;
	logic [9*32-1:0] val_rd_q;
	logic [9*32-1:0] val_s_q;
	logic [31:0]   k0_q;
	logic [31:0]   el_q;
	logic [3:0]    lane_q;
	logic signed [48:0] prod_s2;
	logic signed [32:0] diff_ab;
	logic [32:0]   sum;
	logic [15:0]   alpha;
	logic [31:0]   a_val;
	logic [31:0]   b_val;
	logic [31:0]   k1;
	logic [31:0]   den;
	logic [31:0]   el_d;
	logic [AW-1:0] last_idx;
	logic          div_start_q;
	logic          div_done;

	assign last_idx = AW'(row_count_q - CW'(1));
	assign sum = {1'b0, run_time_q} + {1'b0, time_value};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			run_time_q  <= '0;
		end else if (cmd.clear) begin
			row_count_q <= '0;
			run_time_q  <= '0;
		end else if (cmd.append) begin
			row_count_q <= row_count_q + CW'(1);
			run_time_q  <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
	end

	// Memory write on append
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			key_mem[AW'(row_count_q)]   <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			delta_mem[AW'(row_count_q)] <= time_value;
			bnum_mem[AW'(row_count_q)]  <= ball_index_in;
			val_mem[AW'(row_count_q)]   <= {distance_in, total_score_in, round_score_in,
				ball_z_in, ball_y_in, ball_x_in, ctrl_z_in, ctrl_y_in, ctrl_x_in};
		end
	end

	// Read address: scan index, or segment start/end
	always_comb begin
		rd_addr = idx_q;
		if (cmd.seg_rd_k0) rd_addr = (idx_q == '0) ? idx_q : idx_q - AW'(1);
		else if (cmd.seg_rd_k1 || cmd.lerp_rd) rd_addr = (idx_q == '0) ? AW'(1) : idx_q;
		else if (cmd.copy_rd) rd_addr = idx_q;
	end

	// Registered memory read
	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.seg_rd_k0 || cmd.seg_rd_k1 || cmd.lerp_rd || cmd.copy_rd) begin
			key_rd_q   <= key_mem[rd_addr];
			delta_rd_q <= delta_mem[rd_addr];
			bnum_rd_q  <= bnum_mem[rd_addr];
			val_rd_q   <= val_mem[rd_addr];
		end
	end

	// Scan index and query time capture
	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			t_q   <= time_value;
			idx_q <= '0;
		end else if (cmd.scan_next) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign k1   = key_rd_q;
	assign den  = (k1 >= k0_q) ? k1 - k0_q : '0;
	assign el_d = (t_q >= key_rd_q) ? t_q - key_rd_q : '0;

	// k0 is read from the memory before k1 and held here
	always_ff @(posedge clk) begin
		if (cmd.seg_rd_k1) begin
			k0_q    <= key_rd_q;
			el_q    <= el_d;
			val_s_q <= val_rd_q;
		end
	end

	// Divider start is registered, so it launches once k0 and k1 are both held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_start_q <= 1'b0;
		else         div_start_q <= cmd.div_start;
	end
	kli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.el     (el_q),
		.den    (den),
		.done   (div_done),
		.alpha  (alpha)
	);

	// Lerp lane selection
	always_comb begin
		a_val = val_s_q[lane_q*32 +: 32];
		b_val = val_rd_q[lane_q*32 +: 32];
	end

	assign diff_ab = $signed({b_val[31], b_val}) - $signed({a_val[31], a_val});

	// Shared lerp: multiply stage then shift-add stage
	always_ff @(posedge clk) begin
		if (cmd.lerp_mul) begin
			prod_s2 <= 49'(diff_ab) * 49'($signed({1'b0, alpha}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lane_q <= '0;
		else if (cmd.capture_in) lane_q <= '0;
		else if (cmd.lerp_add) lane_q <= (lane_q == 4'd8) ? '0 : lane_q + 4'd1;
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.set_empty) begin
			for (int k = 0; k < 9; k++) res_q[k] <= '0;
			elapsed_q    <= '0;
		end else if (cmd.lerp_add) begin
			res_q[lane_q] <= a_val + prod_s2[47:16];
			elapsed_q     <= el_q;
		end else if (cmd.copy_wr) begin
			for (int k = 0; k < 9; k++) res_q[k] <= val_rd_q[k*32 +: 32];
			elapsed_q     <= delta_rd_q;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) empty_q <= 1'b0;
		else if (cmd.set_empty) empty_q <= 1'b1;
		else if (cmd.capture_in) empty_q <= 1'b0;
	end
	// Ball number of the segment start, or of the copied row
	always_ff @(posedge clk) begin
		if (cmd.set_empty) ball_index_q <= '0;
		else if (cmd.seg_rd_k1 || cmd.copy_wr) ball_index_q <= bnum_rd_q;
	end

	// Status
	always_comb begin
		stat            = '0;
		stat.empty      = (row_count_q == '0);
		stat.full       = (row_count_q >= CW'(MAX_ROWS));
		stat.key_ge     = (key_rd_q >= t_q);
		stat.scan_last  = (idx_q == last_idx);
		stat.scan_first = (idx_q == '0);
		stat.single_row = (row_count_q == CW'(1));
		stat.div_done   = div_done && !div_start_q;
		stat.lerp_last  = (lane_q == 4'd8);
	end
endmodule
`default_nettype wire

@@ src/keyframe_linear_interpolator.sv @@
// Keyframe linear interpolator: row table with piecewise linear lookup.
// Input channel (in_valid/in_stall) carries one operation beat: clear, append or query.
// Clear and append give no result beat; operation 3 is dropped.
// A query gives one result beat on out_valid/out_stall.
// A query scans the keys one by one (one memory port, registered read), then runs
// the 48-step shift-subtract divider, then nine lerps through one shared multiplier.
// A query past the last key or on a one-row table copies a row and skips the divider.
// An empty table answers at once with zeros and table_empty set.
// One item is worked at a time; in_stall is high until the result beat is taken.
// While the receiver stalls, the result holds steady and no new beat is accepted.
// Reset empties the table; the row memories are not cleared.
`default_nettype none
module keyframe_linear_interpolator
	import kli_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MaxRowsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] time_value,
	input  wire logic [31:0] ctrl_x_in,
	input  wire logic [31:0] ctrl_y_in,
	input  wire logic [31:0] ctrl_z_in,
	input  wire logic [31:0] ball_x_in,
	input  wire logic [31:0] ball_y_in,
	input  wire logic [31:0] ball_z_in,
	input  wire logic [15:0] ball_index_in,
	input  wire logic [31:0] round_score_in,
	input  wire logic [31:0] total_score_in,
	input  wire logic [31:0] distance_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      ctrl_x_out,
	output logic [31:0]      ctrl_y_out,
	output logic [31:0]      ctrl_z_out,
	output logic [31:0]      ball_x_out,
	output logic [31:0]      ball_y_out,
	output logic [31:0]      ball_z_out,
	output logic [31:0]      elapsed_out,
	output logic [15:0]      ball_index_out,
	output logic [31:0]      round_score_out,
	output logic [31:0]      total_score_out,
	output logic [31:0]      distance_out,
	output logic             table_empty
);
	cmd_t  cmd;
	stat_t stat;
	logic [31:0] res [9];

	kli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	kli_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.time_value     (time_value),
		.ctrl_x_in      (ctrl_x_in),
		.ctrl_y_in      (ctrl_y_in),
		.ctrl_z_in      (ctrl_z_in),
		.ball_x_in      (ball_x_in),
		.ball_y_in      (ball_y_in),
		.ball_z_in      (ball_z_in),
		.ball_index_in  (ball_index_in),
		.round_score_in (round_score_in),
		.total_score_in (total_score_in),
		.distance_in    (distance_in),
		.res_q          (res),
		.elapsed_q      (elapsed_out),
		.ball_index_q   (ball_index_out),
		.empty_q        (table_empty)
	);

	assign ctrl_x_out      = res[0];
	assign ctrl_y_out      = res[1];
	assign ctrl_z_out      = res[2];
	assign ball_x_out      = res[3];
	assign ball_y_out      = res[4];
	assign ball_z_out      = res[5];
	assign round_score_out = res[6];
	assign total_score_out = res[7];
	assign distance_out    = res[8];
endmodule
`default_nettype wire

@@ src/kli_checker.sv @@
// Port-level checker for the keyframe linear interpolator, with its bind.
`default_nettype none
module kli_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic table_empty
);
	// A result beat is never shown while a new item can be taken
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during result beat");

	// A stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result beat dropped");

	// Stalled result keeps its empty flag
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(table_empty)) else $error("empty flag moved");

	// After a result is taken the input reopens
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !in_stall) else $error("input not reopened");
endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.table_empty (table_empty)
);
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the keyframe linear interpolator: table ops, queries and result checks.
`timescale 1ns / 1ps
module testbench;
	import kli_pkg::*;

	localparam int unsigned TableRows = MaxRowsDefault;
	localparam int MismatchShow = 10;

	typedef struct {
		op_t         op;
		logic [31:0] tval;
		logic [31:0] ctrl [3];
		logic [31:0] ball [3];
		logic [15:0] bnum;
		logic [31:0] score [3];
	} row_beat_t;

	typedef struct {
		logic [31:0] ctrl [3];
		logic [31:0] ball [3];
		logic [31:0] elapsed;
		logic [15:0] bnum;
		logic [31:0] score [3];
		logic        empty;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	wire  in_stall;
	logic [1:0]  operation = 2'd0;
	logic [31:0] time_value = '0;
	logic [31:0] ctrl_x_in = '0, ctrl_y_in = '0, ctrl_z_in = '0;
	logic [31:0] ball_x_in = '0, ball_y_in = '0, ball_z_in = '0;
	logic [15:0] ball_index_in = '0;
	logic [31:0] round_score_in = '0, total_score_in = '0, distance_in = '0;
	wire  out_valid;
	logic out_stall = 1'b0;
	wire [31:0] ctrl_x_out, ctrl_y_out, ctrl_z_out;
	wire [31:0] ball_x_out, ball_y_out, ball_z_out;
	wire [31:0] elapsed_out;
	wire [15:0] ball_index_out;
	wire [31:0] round_score_out, total_score_out, distance_out;
	wire        table_empty;

	keyframe_linear_interpolator dut (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .time_value,
		.ctrl_x_in, .ctrl_y_in, .ctrl_z_in, .ball_x_in, .ball_y_in, .ball_z_in,
		.ball_index_in, .round_score_in, .total_score_in, .distance_in,
		.out_valid, .out_stall, .ctrl_x_out, .ctrl_y_out, .ctrl_z_out,
		.ball_x_out, .ball_y_out, .ball_z_out, .elapsed_out, .ball_index_out,
		.round_score_out, .total_score_out, .distance_out, .table_empty
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the row table
	logic [31:0] key_at [TableRows];
	logic [31:0] delta_at [TableRows];
	logic [31:0] ctrl_at [TableRows][3];
	logic [31:0] ball_at [TableRows][3];
	logic [31:0] score_at [TableRows][3];
	logic [15:0] bnum_at [TableRows];
	int unsigned rows_held = 0;
	logic [31:0] clock_sum = '0;

	row_beat_t pending_beats [$];
	lookup_t   lookups_due [$];
	int errors = 0;
	int lookups_seen = 0;
	int beats_sent = 0;
	int send_idle = 0, recv_idle = 0;
	logic beat_taken = 1'b0;

	// a + floor((b - a) * alpha / 2^16)
	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [15:0] alpha);
		logic signed [63:0] sa, p;
		sa = {{32{a[31]}}, a};
		p = ({{32{b[31]}}, b} - sa) * $signed({48'd0, alpha});
		return 32'(sa + (p >>> 16));
	endfunction

	function automatic void model_beat(row_beat_t b);
		lookup_t r;
		int unsigned hit, s, e;
		logic found;
		logic [32:0] sum;
		logic [31:0] el, den;
		logic [63:0] q;
		logic [15:0] alpha;
		case (b.op)
			OP_CLEAR: begin
				rows_held = 0;
				clock_sum = '0;
			end
			OP_APPEND: begin
				if (rows_held < TableRows) begin
					sum = {1'b0, clock_sum} + b.tval;
					clock_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					key_at[rows_held] = clock_sum;
					delta_at[rows_held] = b.tval;
					ctrl_at[rows_held] = b.ctrl;
					ball_at[rows_held] = b.ball;
					score_at[rows_held] = b.score;
					bnum_at[rows_held] = b.bnum;
					rows_held++;
				end
			end
			OP_QUERY: begin
				r.ctrl = '{0, 0, 0};
				r.ball = '{0, 0, 0};
				r.score = '{0, 0, 0};
				r.elapsed = '0;
				r.bnum = '0;
				r.empty = 1'b0;
				if (rows_held == 0) begin
					r.empty = 1'b1;
				end else begin
					found = 1'b0;
					hit = 0;
					for (int i = 0; i < rows_held && !found; i++)
						if (key_at[i] >= b.tval) begin
							found = 1'b1;
							hit = i;
						end
					if (!found || (hit == 0 && rows_held == 1)) begin
						s = found ? 0 : rows_held - 1;
						r.ctrl = ctrl_at[s];
						r.ball = ball_at[s];
						r.score = score_at[s];
						r.elapsed = delta_at[s];
						r.bnum = bnum_at[s];
					end else begin
						s = (hit == 0) ? 0 : hit - 1;
						e = (hit == 0) ? 1 : hit;
						el = (b.tval >= key_at[s]) ? b.tval - key_at[s] : '0;
						den = (key_at[e] >= key_at[s]) ? key_at[e] - key_at[s] : '0;
						alpha = '0;
						if (den != 0) begin
							q = {el, 16'd0} / den;
							alpha = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
						end
						for (int j = 0; j < 3; j++) begin
							r.ctrl[j] = blend(ctrl_at[s][j], ctrl_at[e][j], alpha);
							r.ball[j] = blend(ball_at[s][j], ball_at[e][j], alpha);
							r.score[j] = blend(score_at[s][j], score_at[e][j], alpha);
						end
						r.elapsed = el;
						r.bnum = bnum_at[s];
					end
				end
				lookups_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic row_beat_t rand_row(op_t op, logic [31:0] tval);
		row_beat_t b;
		b.op = op;
		b.tval = tval;
		for (int j = 0; j < 3; j++) begin
			b.ctrl[j] = $urandom;
			b.ball[j] = $urandom;
			b.score[j] = $urandom;
		end
		b.bnum = $urandom;
		return b;
	endfunction

	// mostly short deltas so queries land inside segments; a few huge ones saturate
	function automatic logic [31:0] rand_delta();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_when();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return '0;
			default: return $urandom_range(0, clock_sum == 0 ? 32'h10000 : clock_sum + 32'h100);
		endcase
	endfunction

	task automatic add_beat(row_beat_t b);
		pending_beats.push_back(b);
	endtask

	// driver: a new beat goes out once the previous one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || beat_taken) begin
				if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					row_beat_t b;
					b = pending_beats.pop_front();
					in_valid <= 1'b1;
					operation <= b.op;
					time_value <= b.tval;
					{ctrl_x_in, ctrl_y_in, ctrl_z_in} <= {b.ctrl[0], b.ctrl[1], b.ctrl[2]};
					{ball_x_in, ball_y_in, ball_z_in} <= {b.ball[0], b.ball[1], b.ball[2]};
					ball_index_in <= b.bnum;
					{round_score_in, total_score_in, distance_in}
						<= {b.score[0], b.score[1], b.score[2]};
					model_beat(b);
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		beat_taken = in_valid && !in_stall;
		if (beat_taken)
			beats_sent++;
	end

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			errors++;
			if (errors <= MismatchShow)
				$display("mismatch %s: expected %h actual %h (lookup %0d)",
					name, want, got, lookups_seen);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (lookups_due.size() == 0) begin
				errors++;
				if (errors <= MismatchShow)
					$display("mismatch: result beat with no lookup pending");
			end else begin
				lookup_t w;
				w = lookups_due.pop_front();
				check_field("ctrl_x", ctrl_x_out, w.ctrl[0]);
				check_field("ctrl_y", ctrl_y_out, w.ctrl[1]);
				check_field("ctrl_z", ctrl_z_out, w.ctrl[2]);
				check_field("ball_x", ball_x_out, w.ball[0]);
				check_field("ball_y", ball_y_out, w.ball[1]);
				check_field("ball_z", ball_z_out, w.ball[2]);
				check_field("elapsed", elapsed_out, w.elapsed);
				check_field("ball_index", {16'd0, ball_index_out}, {16'd0, w.bnum});
				check_field("round_score", round_score_out, w.score[0]);
				check_field("total_score", total_score_out, w.score[1]);
				check_field("distance", distance_out, w.score[2]);
				check_field("table_empty", {31'd0, table_empty}, {31'd0, w.empty});
			end
			lookups_seen++;
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() > 0 || in_valid || lookups_due.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		row_beat_t b;
		int target;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, single row, clamping, saturation, zero-length segment
		send_idle = 30;
		recv_idle = 62;
		add_beat(rand_row(OP_QUERY, 32'h0));
		add_beat(rand_row(OP_NONE, 32'hFFFF_FFFF));
		add_beat(rand_row(OP_APPEND, 32'h0002_0000));
		add_beat(rand_row(OP_QUERY, 32'h0));
		add_beat(rand_row(OP_QUERY, 32'hFFFF_FFFF));
		b = rand_row(OP_APPEND, 32'h0);
		b.ctrl = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
		b.ball = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		b.bnum = 16'hFFFF;
		add_beat(b);
		b = rand_row(OP_APPEND, 32'h0003_0000);
		b.ctrl = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		b.ball = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
		b.bnum = 16'h0;
		add_beat(b);
		add_beat(rand_row(OP_QUERY, 32'h0001_0000));
		add_beat(rand_row(OP_QUERY, 32'h0002_0000));
		add_beat(rand_row(OP_QUERY, 32'h0003_8000));
		add_beat(rand_row(OP_QUERY, 32'h0004_FFFF));
		add_beat(rand_row(OP_QUERY, 32'h0005_0000));
		add_beat(rand_row(OP_APPEND, 32'hFFFF_FFFF));
		add_beat(rand_row(OP_APPEND, 32'h1234_5678));
		add_beat(rand_row(OP_QUERY, 32'hFFFF_FFFE));
		add_beat(rand_row(OP_QUERY, 32'hFFFF_FFFF));
		add_beat(rand_row(OP_CLEAR, 32'h0));
		add_beat(rand_row(OP_QUERY, 32'h0000_1000));
		add_beat(rand_row(OP_APPEND, 32'h0001_0000));
		add_beat(rand_row(OP_APPEND, 32'h0001_0000));
		add_beat(rand_row(OP_QUERY, 32'h0000_8000));
		wait_drained();

		// fill the table to the brim and append past it
		send_idle = 0;
		recv_idle = 0;
		add_beat(rand_row(OP_CLEAR, 32'h0));
		for (int i = 0; i < TableRows + 2; i++)
			add_beat(rand_row(OP_APPEND, $urandom_range(0, 32'h0000_2000)));
		wait_drained();
		for (int i = 0; i < 6; i++)
			add_beat(rand_row(OP_QUERY, rand_when()));
		wait_drained();

		// random: short tables mostly, queries inside and around them
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 30 : (ph == 1) ? 62 : 0;
			recv_idle = (ph == 0) ? 62 : (ph == 1) ? 30 : 0;
			target = beats_sent + 140;
			while (beats_sent < target) begin
				case ($urandom_range(0, 19))
					0: add_beat(rand_row(OP_CLEAR, $urandom));
					1: add_beat(rand_row(OP_NONE, $urandom));
					2, 3, 4, 5, 6, 7: add_beat(rand_row(OP_APPEND, rand_delta()));
					default: add_beat(rand_row(OP_QUERY, 32'h0));
				endcase
				// query time is picked once the table state is known
				b = pending_beats.pop_back();
				if (b.op == OP_QUERY)
					b.tval = rand_when();
				add_beat(b);
				wait_drained();
				if (rows_held > 40 && $urandom_range(0, 3) == 0)
					add_beat(rand_row(OP_CLEAR, 32'h0));
			end
		end
		wait_drained();
		repeat (700) @(posedge clk);

		$display("ran %0d input beats, %0d lookup results checked, idle mixes and full table",
			beats_sent, lookups_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end
endmodule
